// ----- design/rlfe_pkg.sv -----
// Shared types and constants for the RGB LED frame encoder.
// Used by rlfe_scale and rgb_led_frame_encoder; depends on nothing else.
package rlfe_pkg;

  // Default sizes handed to the top level parameters.
  localparam int NUM_LEDS_DEF    = 8;
  localparam int RESET_SLOTS_DEF = 256;

  // Field widths.
  localparam int CH_W    = 8;            // one color channel
  localparam int GRB_W   = 3 * CH_W;     // stored pixel word
  localparam int PCT_W   = 7;            // clamped brightness, 1..100
  localparam int PROD_W  = CH_W + PCT_W; // channel * brightness
  localparam int DUTY_W  = 6;
  localparam int BIT_W   = 5;            // bit position inside a pixel word
  localparam int CMD_W   = 2;

  localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);
  localparam logic [PCT_W-1:0] PCT_MIN = PCT_W'(1);
  localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(GRB_W - 1);

  // Duty reset values.
  localparam logic [DUTY_W-1:0] DUTY_ONE_RST  = DUTY_W'(27);
  localparam logic [DUTY_W-1:0] DUTY_ZERO_RST = DUTY_W'(13);
  localparam logic [DUTY_W-1:0] DUTY_OFF_RST  = DUTY_W'(12);

  // Input transaction kinds; the last code is unused and dropped.
  typedef enum logic [CMD_W-1:0] {
    CMD_SET   = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_DUTY_ONE  = 2'd0,
    REG_DUTY_ZERO = 2'd1,
    REG_DUTY_OFF  = 2'd2
  } reg_idx_t;

  // Request to the brightness scaler.
  typedef struct packed {
    logic                 start;
    logic [GRB_W-1:0]     rgb;
    logic [PCT_W-1:0]     pct;
  } scale_req_t;

endpackage

// ----- design/rlfe_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Holds the pixel words of the frame encoder; no dependencies.
module rlfe_ram #(
  parameter int WIDTH  = 24,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read of the written address returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/rlfe_scale.sv -----
// Bit-serial brightness scaler: three channel lanes computing channel * pct / 100.
// Depends on rlfe_pkg for widths and the request struct.
module rlfe_scale (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rlfe_pkg::scale_req_t         req,
  output logic                         done,
  output logic [rlfe_pkg::GRB_W-1:0]   grb
);

  localparam int LANES = 3;
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(rlfe_pkg::PCT_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(rlfe_pkg::PROD_W - 1);
  localparam logic [rlfe_pkg::CH_W:0] DIVISOR = 9'(100);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV
  } state_t;

  state_t                          state_r, state_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic                            done_r, done_nxt;
  logic [rlfe_pkg::PCT_W-1:0]      mplier_r, mplier_nxt;
  logic [rlfe_pkg::PROD_W-1:0]     acc_r [LANES];
  logic [rlfe_pkg::PROD_W-1:0]     acc_nxt [LANES];
  logic [rlfe_pkg::PROD_W-1:0]     mcand_r [LANES];
  logic [rlfe_pkg::PROD_W-1:0]     mcand_nxt [LANES];
  logic [rlfe_pkg::PCT_W-1:0]      rem_r [LANES];
  logic [rlfe_pkg::PCT_W-1:0]      rem_nxt [LANES];
  logic [rlfe_pkg::CH_W-1:0]       quo_r [LANES];
  logic [rlfe_pkg::CH_W-1:0]       quo_nxt [LANES];
  logic [rlfe_pkg::CH_W-1:0]       ch_in [LANES];
  logic [rlfe_pkg::CH_W:0]         trial [LANES];
  logic                            fits [LANES];

  // Lane order follows the stored word: green, red, blue.
  assign ch_in[0] = req.rgb[15:8];
  assign ch_in[1] = req.rgb[23:16];
  assign ch_in[2] = req.rgb[7:0];

  // Shift-add multiply over the brightness bits, then restoring division by 100.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    mplier_nxt = mplier_r;
    for (int i = 0; i < LANES; i++) begin
      acc_nxt[i]   = acc_r[i];
      mcand_nxt[i] = mcand_r[i];
      rem_nxt[i]   = rem_r[i];
      quo_nxt[i]   = quo_r[i];
      trial[i]     = {1'b0, rem_r[i], acc_r[i][rlfe_pkg::PROD_W-1]};
      fits[i]      = (trial[i] >= DIVISOR);
    end
    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          mplier_nxt = req.pct;
          cnt_nxt    = '0;
          state_nxt  = S_MUL;
          for (int i = 0; i < LANES; i++) begin
            acc_nxt[i]   = '0;
            mcand_nxt[i] = rlfe_pkg::PROD_W'(ch_in[i]);
          end
        end
      end
      S_MUL: begin
        for (int i = 0; i < LANES; i++) begin
          if (mplier_r[0]) begin
            acc_nxt[i] = acc_r[i] + mcand_r[i];
          end
          mcand_nxt[i] = {mcand_r[i][rlfe_pkg::PROD_W-2:0], 1'b0};
        end
        mplier_nxt = {1'b0, mplier_r[rlfe_pkg::PCT_W-1:1]};
        if (cnt_r == MUL_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_DIV;
          for (int i = 0; i < LANES; i++) begin
            rem_nxt[i] = '0;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DIV: begin
        for (int i = 0; i < LANES; i++) begin
          rem_nxt[i] = fits[i] ? rlfe_pkg::PCT_W'(trial[i] - DIVISOR)
                               : rlfe_pkg::PCT_W'(trial[i]);
          quo_nxt[i] = {quo_r[i][rlfe_pkg::CH_W-2:0], fits[i]};
          acc_nxt[i] = {acc_r[i][rlfe_pkg::PROD_W-2:0], 1'b0};
        end
        if (cnt_r == DIV_LAST) begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, counter and done flag; lane datapath registers need no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
    mplier_r <= mplier_nxt;
    for (int i = 0; i < LANES; i++) begin
      acc_r[i]   <= acc_nxt[i];
      mcand_r[i] <= mcand_nxt[i];
      rem_r[i]   <= rem_nxt[i];
      quo_r[i]   <= quo_nxt[i];
    end
  end

  assign done = done_r;
  assign grb  = {quo_r[0], quo_r[1], quo_r[2]};

  // The lane 0 remainder stays below the divisor during the division phase.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r[0] < rlfe_pkg::PCT_MAX)
    else $error("scaler remainder out of range");

  // A new request is never seen while the lanes are busy.
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_DIV) |-> !req.start)
    else $error("scaler restarted while busy");

  // Done pulses only as the division phase ends.
  a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(state_r) == S_DIV && state_r == S_IDLE)
    else $error("scaler done without division");

endmodule

// ----- design/rgb_led_frame_encoder.sv -----
// RGB LED frame encoder: pixel store, brightness scaling and PWM slot sequencing.
// Depends on rlfe_pkg, rlfe_scale and rlfe_ram.
//
// Usage. Input transactions arrive on in_* with the command kind on in_tuser:
// set color writes one LED (index clamped to the last LED, brightness to
// 1..100), start frame begins a frame in on or off mode, and each slot tick
// of a running frame yields one output transaction on out_* carrying the PWM
// duty, with out_tlast on the final reset slot. Ticks outside a frame, starts
// during a frame and the unused command code produce nothing.
// A tick's result is registered and appears in the cycle after acceptance.
// Ticks are taken one per cycle while the receiver keeps up, except that
// in_tready drops in the cycle after each start, each pixel boundary, the
// final slot of a frame and each stored color, for the registered read of
// the pixel RAM. A set color transaction occupies the bit-serial scaler for
// 7 multiply steps, 15 division steps and one write, during which in_tready
// stays low.
// Reset clears the frame state, the pixel valid bits (so every LED reads as
// black) and the duty registers to 27, 13 and 12. If the receiver stalls,
// the result holds on out_tdata and in_tready stays low, so no transaction
// of any kind is taken until the result has been accepted.
module rgb_led_frame_encoder #(
  parameter int NUM_LEDS    = rlfe_pkg::NUM_LEDS_DEF,
  parameter int RESET_SLOTS = rlfe_pkg::RESET_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata: led_index [7:0], color_rgb [31:8], brightness_pct [39:32],
  //           send_on [40], zero [47:41]
  input  logic [47:0] in_tdata,
  // in_tuser: cmd [1:0]
  input  logic [1:0]  in_tuser,
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: duty [5:0], zero [7:6]
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_wdata
);

  localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int PW = $clog2(NUM_LEDS + 1);
  localparam int CW = $clog2(RESET_SLOTS + 1);
  localparam logic [PW-1:0] POS_END  = PW'(NUM_LEDS);
  localparam logic [AW-1:0] LAST_LED = AW'(NUM_LEDS - 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(RESET_SLOTS - 1);

  // Configuration registers.
  logic [rlfe_pkg::DUTY_W-1:0] duty_one_r, duty_zero_r, duty_off_r;

  // Frame state.
  logic                        busy_r, busy_nxt;
  logic                        on_r, on_nxt;
  logic [PW-1:0]               pos_r, pos_nxt;
  logic [rlfe_pkg::BIT_W-1:0]  bit_r, bit_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        calc_busy_r, calc_busy_nxt;
  logic [AW-1:0]               widx_r, widx_nxt;
  logic                        ok_r, ok_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [rlfe_pkg::DUTY_W-1:0] out_duty_r, out_duty_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        vld_r [NUM_LEDS];
  logic                        vld_q_r;

  // Decoded input fields.
  logic                        in_acc;
  rlfe_pkg::cmd_t              cmd;
  logic [7:0]                  led_index;
  logic [rlfe_pkg::GRB_W-1:0]  color_rgb;
  logic [7:0]                  brightness_pct;
  logic                        send_on;
  logic [rlfe_pkg::PCT_W-1:0]  pct_clamped;
  logic                        out_free;
  logic                        pix_lt;
  logic                        event_hit;
  logic [AW-1:0]               rd_addr;
  logic [rlfe_pkg::GRB_W-1:0]  rd_data;
  logic [rlfe_pkg::GRB_W-1:0]  word;
  logic                        cur_bit;
  rlfe_pkg::scale_req_t        sreq;
  logic                        scale_done;
  logic [rlfe_pkg::GRB_W-1:0]  scale_grb;

  assign cmd            = rlfe_pkg::cmd_t'(in_tuser);
  assign led_index      = in_tdata[7:0];
  assign color_rgb      = in_tdata[31:8];
  assign brightness_pct = in_tdata[39:32];
  assign send_on        = in_tdata[40];

  // Handshake: one transaction at a time, waiting for an idle scaler, a settled RAM read and a free output.
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !calc_busy_r && ok_r && out_free;
  assign in_acc    = in_tvalid && in_tready;

  // Brightness clamp to 1..100.
  always_comb begin
    if (brightness_pct > 8'(rlfe_pkg::PCT_MAX)) begin
      pct_clamped = rlfe_pkg::PCT_MAX;
    end else if (brightness_pct == 8'd0) begin
      pct_clamped = rlfe_pkg::PCT_MIN;
    end else begin
      pct_clamped = brightness_pct[rlfe_pkg::PCT_W-1:0];
    end
  end

  assign sreq.start = in_acc && (cmd == rlfe_pkg::CMD_SET);
  assign sreq.rgb   = color_rgb;
  assign sreq.pct   = pct_clamped;

  rlfe_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sreq),
    .done  (scale_done),
    .grb   (scale_grb)
  );

  // Pixel store; unwritten entries read as black through the valid bits.
  assign pix_lt  = (pos_r < POS_END);
  assign rd_addr = pix_lt ? pos_r[AW-1:0] : '0;

  rlfe_ram #(
    .WIDTH (rlfe_pkg::GRB_W),
    .DEPTH (NUM_LEDS)
  ) u_ram (
    .clk   (clk),
    .we    (scale_done),
    .waddr (widx_r),
    .wdata (scale_grb),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign word    = vld_q_r ? rd_data : '0;
  assign cur_bit = word[bit_r];

  // Command handling and slot sequencing.
  always_comb begin
    busy_nxt      = busy_r;
    on_nxt        = on_r;
    pos_nxt       = pos_r;
    bit_nxt       = bit_r;
    cnt_nxt       = cnt_r;
    calc_busy_nxt = calc_busy_r;
    widx_nxt      = widx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_duty_nxt  = out_duty_r;
    out_last_nxt  = out_last_r;
    event_hit     = scale_done;
    if (scale_done) begin
      calc_busy_nxt = 1'b0;
    end
    if (in_acc) begin
      unique case (cmd)
        rlfe_pkg::CMD_SET: begin
          calc_busy_nxt = 1'b1;
          widx_nxt = ({1'b0, led_index} >= 9'(NUM_LEDS)) ? LAST_LED : led_index[AW-1:0];
        end
        rlfe_pkg::CMD_START: begin
          if (!busy_r) begin
            busy_nxt  = 1'b1;
            on_nxt    = send_on;
            pos_nxt   = '0;
            bit_nxt   = rlfe_pkg::BIT_TOP;
            cnt_nxt   = '0;
            event_hit = 1'b1;
          end
        end
        rlfe_pkg::CMD_TICK: begin
          if (busy_r) begin
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b0;
            if (pix_lt) begin
              if (on_r) begin
                out_duty_nxt = cur_bit ? duty_one_r : duty_zero_r;
              end else begin
                out_duty_nxt = duty_off_r;
              end
              if (bit_r == '0) begin
                bit_nxt   = rlfe_pkg::BIT_TOP;
                pos_nxt   = pos_r + 1'b1;
                event_hit = 1'b1;
              end else begin
                bit_nxt = bit_r - 1'b1;
              end
            end else begin
              out_duty_nxt = '0;
              if (cnt_r == CNT_LAST) begin
                out_last_nxt = 1'b1;
                busy_nxt     = 1'b0;
                pos_nxt      = '0;
                bit_nxt      = rlfe_pkg::BIT_TOP;
                cnt_nxt      = '0;
                event_hit    = 1'b1;
              end else begin
                cnt_nxt = cnt_r + 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    ok_nxt = !event_hit;
  end

  // Control and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      on_r        <= 1'b0;
      pos_r       <= '0;
      bit_r       <= rlfe_pkg::BIT_TOP;
      cnt_r       <= '0;
      calc_busy_r <= 1'b0;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      on_r        <= on_nxt;
      pos_r       <= pos_nxt;
      bit_r       <= bit_nxt;
      cnt_r       <= cnt_nxt;
      calc_busy_r <= calc_busy_nxt;
      ok_r        <= ok_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
    widx_r     <= widx_nxt;
    out_duty_r <= out_duty_nxt;
  end

  // Pixel valid bits, read alongside the RAM so both line up.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        vld_r[i] <= 1'b0;
      end
      vld_q_r <= 1'b0;
    end else begin
      if (scale_done) begin
        vld_r[widx_r] <= 1'b1;
      end
      vld_q_r <= vld_r[rd_addr];
    end
  end

  // Duty registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_one_r  <= rlfe_pkg::DUTY_ONE_RST;
      duty_zero_r <= rlfe_pkg::DUTY_ZERO_RST;
      duty_off_r  <= rlfe_pkg::DUTY_OFF_RST;
    end else if (cfg_we) begin
      unique case (rlfe_pkg::reg_idx_t'(cfg_index))
        rlfe_pkg::REG_DUTY_ONE:  duty_one_r  <= cfg_wdata;
        rlfe_pkg::REG_DUTY_ZERO: duty_zero_r <= cfg_wdata;
        rlfe_pkg::REG_DUTY_OFF:  duty_off_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_duty_r};
  assign out_tlast  = out_last_r;

  // A frame only ends together with its flagged final slot.
  a_end_flag: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> out_valid_r && out_last_r)
    else $error("frame ended without a last slot");

  // The final slot is a reset slot and carries zero duty.
  a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_duty_r == '0)
    else $error("last slot with nonzero duty");

  // Scaler results arrive only for an outstanding set color.
  a_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    scale_done |-> calc_busy_r)
    else $error("stray scaler result");

  // The bit position stays inside the pixel word.
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= rlfe_pkg::BIT_TOP)
    else $error("bit position out of range");

endmodule
